FILE: rtl/packet_xor_decode_checksum_core_assert.svh
// Assertion macros shared by the packet XOR decoder RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PACKET_XOR_DECODE_CHECKSUM_CORE_ASSERT_SVH
`define PACKET_XOR_DECODE_CHECKSUM_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PXD_ASSERT_SAME(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PXD_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pxd_pkg.sv
// Package for the packet XOR decoder: item structs shared by the datapath
// and the top level. Depends on nothing.
package pxd_pkg;

  localparam int unsigned ByteW = 8;

  // One received byte with its framing flags.
  typedef struct packed {
    logic             last_byte;
    logic             first_byte;
    logic [ByteW-1:0] random_key;
    logic [ByteW-1:0] cipher_byte;
  } in_item_t;

  // One decoded byte with its status flags.
  typedef struct packed {
    logic             packet_end;
    logic             checksum_ok;
    logic             is_checksum;
    logic [ByteW-1:0] plain_byte;
  } out_item_t;

endpackage

FILE: rtl/pxd_decode.sv
// Chained two-stage XOR decode and running checksum for one byte per cycle while step_i is high.
// Depends on pxd_pkg for the item structs.
module pxd_decode
  import pxd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  in_item_t         item_i,
  input  logic [ByteW-1:0] static_key_i,
  output out_item_t        result_o
);

  logic [ByteW-1:0] prev_cipher_q, prev_cipher_d;
  logic [ByteW-1:0] prev_plain_q, prev_plain_d;
  logic [ByteW-1:0] position_q, position_d;
  logic [ByteW-1:0] held_checksum_q, held_checksum_d;
  logic [ByteW-1:0] payload_sum_q, payload_sum_d;

  logic [ByteW-1:0] base_cipher;
  logic [ByteW-1:0] base_plain;
  logic [ByteW-1:0] base_sum;
  logic [ByteW-1:0] mid_byte;
  logic [ByteW-1:0] out_byte;

  // A packet start restarts the chain and the sum before this byte is decoded.
  always_comb begin
    base_cipher = item_i.first_byte ? '0 : prev_cipher_q;
    base_plain  = item_i.first_byte ? '0 : prev_plain_q;
    base_sum    = item_i.first_byte ? '0 : payload_sum_q;
    position_d  = (item_i.first_byte ? '0 : position_q) + ByteW'(1);

    mid_byte = item_i.cipher_byte ^ (base_cipher + static_key_i + position_d);
    out_byte = mid_byte ^ (base_plain + item_i.random_key + position_d);

    prev_cipher_d   = item_i.cipher_byte;
    prev_plain_d    = mid_byte;
    held_checksum_d = item_i.first_byte ? out_byte : held_checksum_q;
    payload_sum_d   = item_i.first_byte ? base_sum : base_sum + out_byte;

    result_o.plain_byte  = out_byte;
    result_o.is_checksum = item_i.first_byte;
    result_o.checksum_ok = item_i.last_byte && (payload_sum_d == held_checksum_d);
    result_o.packet_end  = item_i.last_byte;
  end

  // Chain state advances once per decoded byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_cipher_q   <= '0;
      prev_plain_q    <= '0;
      position_q      <= '0;
      held_checksum_q <= '0;
      payload_sum_q   <= '0;
    end else if (step_i) begin
      prev_cipher_q   <= prev_cipher_d;
      prev_plain_q    <= prev_plain_d;
      position_q      <= position_d;
      held_checksum_q <= held_checksum_d;
      payload_sum_q   <= payload_sum_d;
    end
  end

endmodule

FILE: rtl/packet_xor_decode_checksum_core.sv
// Top level of the packet XOR decoder with sum checksum.
// Depends on pxd_pkg, pxd_decode and packet_xor_decode_checksum_core_assert.svh.
//
// Usage:
//   The slave stream carries one received packet byte per transaction: the
//   checksum byte first (tuser high), then the payload, the final byte with
//   tlast high. The master stream returns one decoded byte per transaction;
//   tuser[0] marks the checksum byte, tuser[1] reports a matching checksum on
//   the final byte, and tlast copies the input tlast.
//   The static key is written through cfg_we_i / cfg_wdata_i; the user must write it
//   only while no bytes are in flight, as the block does not enforce it; it resets to zero.
//   An accepted input transaction is captured in the input register, decoded, and
//   captured in the result register, which drives the output transaction: one input
//   register and one result register, with the decode between them.
//   Throughput is one byte per cycle while the receiver keeps m_axis_tready high;
//   the chained decode state is updated as each byte is decoded.
//   When the receiver stalls, the result register holds and the input register takes
//   one more byte if it is empty, then tready falls until the output drains.
//   Reset clears the chain state, the checksum, the key and both valid flags.
module packet_xor_decode_checksum_core
  import pxd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // Configuration write port for the static key.
  input  logic             cfg_we_i,
  input  logic [ByteW-1:0] cfg_wdata_i,
  // Input stream.
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,   // [7:0] cipher_byte, [15:8] random_key
  input  logic             s_axis_tuser,   // [0] first_byte
  input  logic             s_axis_tlast,   // last_byte
  // Output stream.
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] plain_byte
  output logic [1:0]       m_axis_tuser,   // [0] is_checksum, [1] checksum_ok
  output logic             m_axis_tlast    // packet_end
);

  `include "packet_xor_decode_checksum_core_assert.svh"

  logic [ByteW-1:0] static_key_q;
  logic             in_valid_q;
  in_item_t         in_item_q;
  logic             out_valid_q;
  out_item_t        out_item_q;
  out_item_t        result;
  logic             advance;
  logic             step;

  // The pipeline moves when the result register is free or being drained.
  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = advance && in_valid_q;
  assign s_axis_tready = !in_valid_q || advance;

  // Static key register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      static_key_q <= '0;
    end else if (cfg_we_i) begin
      static_key_q <= cfg_wdata_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.cipher_byte <= s_axis_tdata[7:0];
      in_item_q.random_key  <= s_axis_tdata[15:8];
      in_item_q.first_byte  <= s_axis_tuser;
      in_item_q.last_byte   <= s_axis_tlast;
    end
  end

  // Decode datapath and chain state.
  pxd_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .item_i       (in_item_q),
    .static_key_i (static_key_q),
    .result_o     (result)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_item_q <= result;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_item_q.plain_byte;
  assign m_axis_tuser[0] = out_item_q.is_checksum;
  assign m_axis_tuser[1] = out_item_q.checksum_ok;
  assign m_axis_tlast    = out_item_q.packet_end;

  // A checksum verdict is only ever reported on the final byte.
  `PXD_ASSERT_SAME(a_ok_on_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1],
    m_axis_tlast, "checksum_ok raised on a byte that is not the packet end")

  // Back-pressure only when both registers are full and the output stalls.
  `PXD_ASSERT_SAME(a_ready_low_full, clk_i, rst_ni, !s_axis_tready,
    in_valid_q && out_valid_q && !m_axis_tready, "input stalled without a full pipeline")

  // A decoded start byte shows up as the checksum on the next output.
  `PXD_ASSERT_NEXT(a_start_to_checksum, clk_i, rst_ni, step && in_item_q.first_byte,
    m_axis_tvalid && m_axis_tuser[0], "packet start not reported as checksum byte")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for packet_xor_decode_checksum_core: encoded packets and
// stray bytes go in over the slave stream, decoded bytes are checked on the master
// stream. Depends on pxd_pkg and the decoder RTL only.
module tb_top;
  import pxd_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [ByteW-1:0] cfg_wdata_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [15:0]      s_axis_tdata = '0;   // [7:0] cipher_byte, [15:8] random_key
  logic             s_axis_tuser = 1'b0; // [0] first_byte
  logic             s_axis_tlast = 1'b0; // last_byte
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;        // [7:0] plain_byte
  logic [1:0]       m_axis_tuser;        // [0] is_checksum, [1] checksum_ok
  logic             m_axis_tlast;        // packet_end

  packet_xor_decode_checksum_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Received bytes waiting to be sent, and decoded bytes waiting to come out.
  in_item_t  rx_bytes[$];
  out_item_t decoded_q[$];
  int        fail_count = 0;

  // Decoder state as the testbench tracks it.
  logic [ByteW-1:0] key_byte = '0;
  logic [ByteW-1:0] chain_cipher = '0;
  logic [ByteW-1:0] chain_plain = '0;
  logic [ByteW-1:0] chain_pos = '0;
  logic [ByteW-1:0] held_sum = '0;
  logic [ByteW-1:0] payload_sum = '0;

  // Decodes one received byte and advances the chained state.
  function automatic out_item_t decode_byte(in_item_t it);
    out_item_t        res;
    logic [ByteW-1:0] p;
    logic [ByteW-1:0] q;
    if (it.first_byte) begin
      chain_cipher = '0;
      chain_plain  = '0;
      chain_pos    = '0;
      payload_sum  = '0;
    end
    chain_pos    = chain_pos + 8'd1;
    p            = it.cipher_byte ^ (chain_cipher + key_byte + chain_pos);
    q            = p ^ (chain_plain + it.random_key + chain_pos);
    chain_cipher = it.cipher_byte;
    chain_plain  = p;
    if (it.first_byte) begin
      held_sum = q;
    end else begin
      payload_sum = payload_sum + q;
    end
    res.plain_byte  = q;
    res.is_checksum = it.first_byte;
    res.checksum_ok = it.last_byte && (payload_sum == held_sum);
    res.packet_end  = it.last_byte;
    return res;
  endfunction

  function automatic in_item_t make_item(logic [7:0] c, logic [7:0] rk, logic f, logic l);
    in_item_t it;
    it.cipher_byte = c;
    it.random_key  = rk;
    it.first_byte  = f;
    it.last_byte   = l;
    return it;
  endfunction

  // Encodes a checksum byte plus payload with the current key and queues it. A
  // corrupted packet carries a wrong checksum; an open one never sets last.
  task automatic encode_packet(input logic [7:0] body[$], input logic [7:0] rk,
                               input bit corrupt, input bit close);
    logic [7:0] sum;
    logic [7:0] q;
    logic [7:0] p;
    logic [7:0] c;
    logic [7:0] prev_c;
    logic [7:0] prev_p;
    logic [7:0] pos;
    int         n;
    int         k;
    sum = '0;
    foreach (body[i]) sum = sum + body[i];
    if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
    prev_c = '0;
    prev_p = '0;
    pos    = '0;
    n      = body.size() + 1;
    for (k = 0; k < n; k++) begin
      q      = (k == 0) ? sum : body[k-1];
      pos    = pos + 8'd1;
      p      = q ^ (prev_p + rk + pos);
      c      = p ^ (prev_c + key_byte + pos);
      prev_c = c;
      prev_p = p;
      rx_bytes.push_back(make_item(c, rk, k == 0, close && (k == n - 1)));
    end
  endtask

  task automatic queue_random_packet(input int len, input bit corrupt, input bit close);
    logic [7:0] body[$];
    int         k;
    for (k = 0; k < len; k++) body.push_back(8'($urandom));
    encode_packet(body, 8'($urandom), corrupt, close);
  endtask

  // Random bytes with random framing flags.
  task automatic queue_noise(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      rx_bytes.push_back(make_item(8'($urandom), 8'($urandom),
                                   $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0));
    end
  endtask

  // Short directed sequence run with the reset key.
  task automatic queue_directed();
    logic [7:0] body[$];
    // Bytes before any packet start continue the reset chain.
    rx_bytes.push_back(make_item(8'hFF, 8'h00, 1'b0, 1'b0));
    rx_bytes.push_back(make_item(8'h00, 8'hFF, 1'b0, 1'b1));
    // Empty payload: a zero checksum matches, a nonzero one does not.
    encode_packet(body, 8'h5A, 1'b0, 1'b1);
    rx_bytes.push_back(make_item(8'hFF, 8'hFF, 1'b1, 1'b1));
    // Good packet with extreme payload values.
    body.push_back(8'hFF);
    body.push_back(8'h01);
    encode_packet(body, 8'h00, 1'b0, 1'b1);
    // Raw extreme cipher bytes.
    rx_bytes.push_back(make_item(8'hFF, 8'hFF, 1'b1, 1'b0));
    rx_bytes.push_back(make_item(8'h00, 8'hFF, 1'b0, 1'b0));
    rx_bytes.push_back(make_item(8'hFF, 8'h00, 1'b0, 1'b1));
    // A packet cut short by a new start.
    rx_bytes.push_back(make_item(8'h12, 8'h34, 1'b1, 1'b0));
    rx_bytes.push_back(make_item(8'h56, 8'h34, 1'b0, 1'b0));
    queue_random_packet(4, 1'b0, 1'b1);
    // Bytes after a packet end without a new start.
    rx_bytes.push_back(make_item(8'hA5, 8'h5A, 1'b0, 1'b0));
    rx_bytes.push_back(make_item(8'h5A, 8'hA5, 1'b0, 1'b1));
    queue_random_packet(3, 1'b1, 1'b1);
  endtask

  // Mostly well-formed packets, some broken ones, some noise.
  task automatic queue_phase(input int target, input bit with_wrap);
    int r;
    if (with_wrap) queue_random_packet($urandom_range(256, 320), 1'b0, 1'b1);
    while (rx_bytes.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        queue_random_packet($urandom_range(0, 20), $urandom_range(0, 3) == 0, 1'b1);
      end else if (r < 82) begin
        queue_random_packet($urandom_range(0, 8), 1'b0, 1'b0);
      end else begin
        queue_noise($urandom_range(1, 6));
      end
    end
  endtask

  task automatic wait_idle();
    while (rx_bytes.size() != 0 || s_axis_tvalid || decoded_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_key(input logic [7:0] k);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= k;
    key_byte     = k;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // Sender: bursts of random length separated by random gaps.
  in_item_t tx_item;
  int       burst_left = 0;
  int       gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) decoded_q.push_back(decode_byte(tx_item));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (rx_bytes.size() != 0) begin
          tx_item = rx_bytes.pop_front();
          s_axis_tdata  <= {tx_item.random_key, tx_item.cipher_byte};
          s_axis_tuser  <= tx_item.first_byte;
          s_axis_tlast  <= tx_item.last_byte;
          s_axis_tvalid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each output transaction and stalls in changing modes:
  // always ready, scattered stalls, or long stall runs.
  out_item_t want;
  int        ready_mode = 0;
  int        mode_left = 0;
  int        stall_left = 0;
  logic      ready_next;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (decoded_q.size() == 0) begin
          $error("decoded byte %02h arrived with none pending", m_axis_tdata);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          if (m_axis_tdata !== want.plain_byte) begin
            $error("plain_byte: expected %02h, got %02h", want.plain_byte, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tuser[0] !== want.is_checksum) begin
            $error("is_checksum: expected %b, got %b", want.is_checksum, m_axis_tuser[0]);
            fail_count++;
          end
          if (m_axis_tuser[1] !== want.checksum_ok) begin
            $error("checksum_ok: expected %b, got %b", want.checksum_ok, m_axis_tuser[1]);
            fail_count++;
          end
          if (m_axis_tlast !== want.packet_end) begin
            $error("packet_end: expected %b, got %b", want.packet_end, m_axis_tlast);
            fail_count++;
          end
        end
      end
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0: ready_next = 1'b1;
        1: ready_next = ($urandom_range(0, 3) != 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
          end else begin
            ready_next = 1'b1;
            if ($urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 12);
          end
        end
      endcase
      m_axis_tready <= ready_next;
    end
  end

  // Reset, directed bytes, then random phases under different keys.
  logic [7:0] phase_keys[7];

  initial begin
    phase_keys = '{8'hFF, 8'h00, 8'h80, 8'($urandom), 8'h01, 8'($urandom), 8'h7F};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    queue_directed();
    foreach (phase_keys[i]) begin
      wait_idle();
      write_key(phase_keys[i]);
      queue_phase(260, i == 1 || i == 4);
    end
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (decoded_q.size() != 0) begin
      $error("%0d decoded bytes never arrived", decoded_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
